// ===== rtl/gtl_pkg.sv =====
// Shared types, letter codes and the Greek-to-Latin glyph table for the transliterator.
package gtl_pkg;

	// ISO-8859-7 codes of the letters that take part in the nu/mu pairing rules.
	localparam logic [7:0] NU_SM  = 8'd237;
	localparam logic [7:0] NU_CAP = 8'd205;
	localparam logic [7:0] MU_SM  = 8'd236;
	localparam logic [7:0] MU_CAP = 8'd204;
	localparam logic [7:0] TAU_SM  = 8'd244;
	localparam logic [7:0] TAU_CAP = 8'd212;
	localparam logic [7:0] PI_SM   = 8'd240;
	localparam logic [7:0] PI_CAP  = 8'd208;

	localparam int unsigned QUEUE_DEPTH = 2;

	// Letter held back by the front end.
	typedef enum logic [6:0] {
		P_NONE   = 7'b0000001,
		P_SM_M   = 7'b0000010,
		P_SM_N   = 7'b0000100,
		P_CAP_N  = 7'b0001000,
		P_CAP_M  = 7'b0010000,
		P_OWE_D  = 7'b0100000,
		P_OWE_B  = 7'b1000000
	} pend_t;

	// Expansion of one input byte: len is 1 to 3, ch[0] goes out first.
	typedef struct packed {
		logic [1:0]      len;
		logic [2:0][7:0] ch;
	} glyph_t;

	// One queued item: up to four output bytes, chars[0] first.
	typedef struct packed {
		logic [1:0]      cnt_m1;
		logic [3:0][7:0] chars;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic pending_none;
	} fstat_t;

	function automatic glyph_t mk(input logic [1:0] len, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2);
		glyph_t g;
		g.len   = len;
		g.ch[0] = c0;
		g.ch[1] = c1;
		g.ch[2] = c2;
		return g;
	endfunction

	// Bytes without an entry pass through as themselves.
	function automatic glyph_t glyph(input logic [7:0] b);
		glyph_t g;
		case (b)
			8'd193: g = mk(2'd1, "A", 8'd0, 8'd0);
			8'd194: g = mk(2'd1, "V", 8'd0, 8'd0);
			8'd195: g = mk(2'd1, "G", 8'd0, 8'd0);
			8'd196: g = mk(2'd1, "D", 8'd0, 8'd0);
			8'd197: g = mk(2'd1, "E", 8'd0, 8'd0);
			8'd198: g = mk(2'd1, "Z", 8'd0, 8'd0);
			8'd199: g = mk(2'd1, "H", 8'd0, 8'd0);
			8'd200: g = mk(2'd1, "8", 8'd0, 8'd0);
			8'd201: g = mk(2'd1, "I", 8'd0, 8'd0);
			8'd202: g = mk(2'd1, "K", 8'd0, 8'd0);
			8'd203: g = mk(2'd1, "L", 8'd0, 8'd0);
			8'd204: g = mk(2'd1, "M", 8'd0, 8'd0);
			8'd205: g = mk(2'd1, "N", 8'd0, 8'd0);
			8'd206: g = mk(2'd2, "K", "S", 8'd0);
			8'd207: g = mk(2'd1, "O", 8'd0, 8'd0);
			8'd208: g = mk(2'd1, "P", 8'd0, 8'd0);
			8'd209: g = mk(2'd1, "R", 8'd0, 8'd0);
			8'd210: g = mk(2'd1, "S", 8'd0, 8'd0);
			8'd211: g = mk(2'd1, "S", 8'd0, 8'd0);
			8'd212: g = mk(2'd1, "T", 8'd0, 8'd0);
			8'd213: g = mk(2'd1, "Y", 8'd0, 8'd0);
			8'd214: g = mk(2'd1, "F", 8'd0, 8'd0);
			8'd215: g = mk(2'd1, "X", 8'd0, 8'd0);
			8'd216: g = mk(2'd2, "P", "S", 8'd0);
			8'd217: g = mk(2'd1, "W", 8'd0, 8'd0);
			8'd225: g = mk(2'd1, "a", 8'd0, 8'd0);
			8'd226: g = mk(2'd1, "v", 8'd0, 8'd0);
			8'd227: g = mk(2'd1, "g", 8'd0, 8'd0);
			8'd228: g = mk(2'd1, "d", 8'd0, 8'd0);
			8'd229: g = mk(2'd1, "e", 8'd0, 8'd0);
			8'd230: g = mk(2'd1, "z", 8'd0, 8'd0);
			8'd231: g = mk(2'd1, "h", 8'd0, 8'd0);
			8'd232: g = mk(2'd1, "8", 8'd0, 8'd0);
			8'd233: g = mk(2'd1, "i", 8'd0, 8'd0);
			8'd234: g = mk(2'd1, "k", 8'd0, 8'd0);
			8'd235: g = mk(2'd1, "l", 8'd0, 8'd0);
			8'd236: g = mk(2'd1, "m", 8'd0, 8'd0);
			8'd237: g = mk(2'd1, "n", 8'd0, 8'd0);
			8'd238: g = mk(2'd2, "k", "s", 8'd0);
			8'd239: g = mk(2'd1, "o", 8'd0, 8'd0);
			8'd240: g = mk(2'd1, "p", 8'd0, 8'd0);
			8'd241: g = mk(2'd1, "r", 8'd0, 8'd0);
			8'd242: g = mk(2'd1, "s", 8'd0, 8'd0);
			8'd243: g = mk(2'd1, "s", 8'd0, 8'd0);
			8'd244: g = mk(2'd1, "t", 8'd0, 8'd0);
			8'd245: g = mk(2'd1, "y", 8'd0, 8'd0);
			8'd246: g = mk(2'd1, "f", 8'd0, 8'd0);
			8'd247: g = mk(2'd1, "x", 8'd0, 8'd0);
			8'd248: g = mk(2'd2, "p", "s", 8'd0);
			8'd249: g = mk(2'd1, "w", 8'd0, 8'd0);
			8'd182: g = mk(2'd2, "'", "A", 8'd0);
			8'd184: g = mk(2'd2, "'", "E", 8'd0);
			8'd185: g = mk(2'd2, "'", "H", 8'd0);
			8'd186: g = mk(2'd2, "'", "I", 8'd0);
			8'd188: g = mk(2'd2, "'", "O", 8'd0);
			8'd190: g = mk(2'd2, "'", "Y", 8'd0);
			8'd191: g = mk(2'd2, "'", "W", 8'd0);
			8'd220: g = mk(2'd2, "a", "'", 8'd0);
			8'd221: g = mk(2'd2, "e", "'", 8'd0);
			8'd222: g = mk(2'd2, "h", "'", 8'd0);
			8'd223: g = mk(2'd2, "i", "'", 8'd0);
			8'd252: g = mk(2'd2, "o", "'", 8'd0);
			8'd253: g = mk(2'd2, "y", "'", 8'd0);
			8'd254: g = mk(2'd2, "w", "'", 8'd0);
			8'd192: g = mk(2'd3, "i", "'", "\"");
			8'd250: g = mk(2'd2, "i", "\"", 8'd0);
			8'd218: g = mk(2'd2, "\"", "I", 8'd0);
			8'd224: g = mk(2'd3, "y", "'", "\"");
			8'd251: g = mk(2'd2, "y", "\"", 8'd0);
			8'd219: g = mk(2'd2, "\"", "Y", 8'd0);
			default: g = mk(2'd1, b, 8'd0, 8'd0);
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/gtl_channels.sv =====
// Valid/ready channel interfaces for the input bytes and the output characters.
interface gtl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       flush;

	modport source (output valid, output byte_in, output flush, input ready);
	modport sink (input valid, input byte_in, input flush, output ready);
endinterface

interface gtl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink (input valid, input char_out, input last, output ready);
endinterface

// ===== rtl/gtl_front.sv =====
// Front end: accepts input beats, tracks the pending letter and builds output entries.
module gtl_front (
	input  logic              clk,
	input  logic              arst_n,
	gtl_in_if.sink            in_ch,
	input  gtl_pkg::qstat_t   qstat,
	output gtl_pkg::push_t    push,
	output gtl_pkg::fstat_t   fstat
);

	gtl_pkg::pend_t  st_q;
	gtl_pkg::pend_t  ns;
	gtl_pkg::pend_t  idle_ns;
	gtl_pkg::glyph_t g;
	logic            idle_body;
	logic            pre_v;
	logic [7:0]      pre_ch;
	logic            body_v;
	logic [2:0]      total;
	logic [3:0][7:0] chars;
	logic            fire;
	logic [7:0]      b;

	assign b           = in_ch.byte_in;
	assign in_ch.ready = !qstat.full;
	assign fire        = in_ch.valid && in_ch.ready;

	// What a byte does when no letter is held.
	always_comb begin
		idle_ns   = gtl_pkg::P_NONE;
		idle_body = 1'b0;
		case (b)
			gtl_pkg::NU_SM:  idle_ns = gtl_pkg::P_SM_N;
			gtl_pkg::NU_CAP: idle_ns = gtl_pkg::P_CAP_N;
			gtl_pkg::MU_SM:  idle_ns = gtl_pkg::P_SM_M;
			gtl_pkg::MU_CAP: idle_ns = gtl_pkg::P_CAP_M;
			default:         idle_body = 1'b1;
		endcase
	end

	always_comb begin
		g      = gtl_pkg::glyph(b);
		pre_v  = 1'b0;
		pre_ch = 8'd0;
		body_v = 1'b0;
		ns     = gtl_pkg::P_NONE;
		if (in_ch.flush) begin
			pre_v = 1'b1;
			case (st_q)
				gtl_pkg::P_SM_M:  pre_ch = "m";
				gtl_pkg::P_SM_N:  pre_ch = "n";
				gtl_pkg::P_CAP_N: pre_ch = "N";
				gtl_pkg::P_CAP_M: pre_ch = "M";
				gtl_pkg::P_OWE_D: pre_ch = "D";
				gtl_pkg::P_OWE_B: pre_ch = "B";
				default:          pre_v  = 1'b0;
			endcase
		end else begin
			case (st_q)
				gtl_pkg::P_SM_N: begin
					pre_v = 1'b1;
					if (b == gtl_pkg::TAU_SM || b == gtl_pkg::TAU_CAP) begin
						pre_ch = "d";
					end else begin
						pre_ch = "n";
						body_v = 1'b1;
					end
				end
				gtl_pkg::P_SM_M: begin
					pre_v = 1'b1;
					if (b == gtl_pkg::PI_SM || b == gtl_pkg::PI_CAP) begin
						pre_ch = "b";
					end else begin
						pre_ch = "m";
						body_v = 1'b1;
					end
				end
				gtl_pkg::P_CAP_N: begin
					if (b == gtl_pkg::TAU_SM) begin
						ns = gtl_pkg::P_OWE_D;
					end else if (b == gtl_pkg::TAU_CAP) begin
						pre_v  = 1'b1;
						pre_ch = "D";
					end else begin
						pre_v  = 1'b1;
						pre_ch = "N";
						body_v = 1'b1;
					end
				end
				gtl_pkg::P_CAP_M: begin
					if (b == gtl_pkg::PI_SM) begin
						ns = gtl_pkg::P_OWE_B;
					end else if (b == gtl_pkg::PI_CAP) begin
						pre_v  = 1'b1;
						pre_ch = "B";
					end else begin
						pre_v  = 1'b1;
						pre_ch = "M";
						body_v = 1'b1;
					end
				end
				gtl_pkg::P_OWE_D: begin
					pre_v  = 1'b1;
					pre_ch = "D";
					ns     = idle_ns;
					body_v = idle_body;
				end
				gtl_pkg::P_OWE_B: begin
					pre_v  = 1'b1;
					pre_ch = "B";
					ns     = idle_ns;
					body_v = idle_body;
				end
				default: begin
					ns     = idle_ns;
					body_v = idle_body;
				end
			endcase
		end
	end

	// Pack the prefix letter and the glyph into one entry.
	always_comb begin
		chars = '0;
		if (pre_v) begin
			chars[0]   = pre_ch;
			chars[3:1] = g.ch;
			total      = body_v ? ({1'b0, g.len} + 3'd1) : 3'd1;
		end else begin
			chars[2:0] = g.ch;
			total      = body_v ? {1'b0, g.len} : 3'd0;
		end
	end

	assign push.valid        = fire && (total != 3'd0);
	assign push.entry.chars  = chars;
	assign push.entry.cnt_m1 = 2'(total - 3'd1);
	assign fstat.pending_none = (st_q == gtl_pkg::P_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gtl_pkg::P_NONE;
		end else if (fire) begin
			st_q <= ns;
		end
	end

endmodule

// ===== rtl/gtl_queue.sv =====
// Two-entry queue that decouples the front end from the output sequencer.
module gtl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  gtl_pkg::push_t   push,
	input  logic             pop,
	output gtl_pkg::entry_t  head,
	output gtl_pkg::qstat_t  qstat
);

	localparam int unsigned AW = $clog2(gtl_pkg::QUEUE_DEPTH);

	gtl_pkg::entry_t mem_q [gtl_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.full  = (count_q == (AW+1)'(gtl_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push.valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= AW'((wr_ptr_q + 1'b1) % gtl_pkg::QUEUE_DEPTH);
			end
			if (do_pop) begin
				rd_ptr_q <= AW'((rd_ptr_q + 1'b1) % gtl_pkg::QUEUE_DEPTH);
			end
			count_q <= count_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/gtl_back.sv =====
// Output sequencer: sends the bytes of each queued entry, one beat per cycle while the sink is ready.
module gtl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  gtl_pkg::entry_t  head,
	input  gtl_pkg::qstat_t  qstat,
	output logic             pop,
	gtl_out_if.source        out_ch
);

	gtl_pkg::entry_t cur_q;
	logic            cur_valid_q;
	logic [1:0]      idx_q;
	logic            is_last;
	logic            fire;

	assign is_last         = (idx_q == cur_q.cnt_m1);
	assign fire            = out_ch.valid && out_ch.ready;
	assign out_ch.valid    = cur_valid_q;
	assign out_ch.char_out = cur_q.chars[idx_q];
	assign out_ch.last     = is_last;
	assign pop             = !qstat.empty && (!cur_valid_q || (fire && is_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (fire) begin
				if (is_last) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/greek_to_latin_transliterator.sv =====
// Top level of the ISO-8859-7 to Latin transliterator.
// Path: an accepted input beat is written into the queue, and the sequencer then loads it
// into its current-entry register, which drives the first output byte.
// Throughput: one input beat per cycle while the two-entry queue has room; the output
// sequencer sends one byte per cycle while the sink is ready, and an item gives 0 to 4 bytes.
// Reset (arst_n low, asynchronous) clears the held letter, the queue and the sequencer.
module greek_to_latin_transliterator (
	input  logic       clk,
	input  logic       arst_n,
	gtl_in_if.sink     in_ch,
	gtl_out_if.source  out_ch
);

	// The front end decides, per input beat, the whole run of output bytes it causes,
	// including any letter that was held back from earlier beats. Items that cause
	// no output (a nu or mu that is held, or a flush with nothing held) leave no entry.
	gtl_pkg::push_t  push;
	gtl_pkg::qstat_t qstat;
	gtl_pkg::fstat_t fstat;
	gtl_pkg::entry_t head;
	logic            pop;

	gtl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.qstat  (qstat),
		.push   (push),
		.fstat  (fstat)
	);

	// The queue lets the front end keep taking beats while the sequencer is
	// still working through a long entry or the output side is stalled.
	gtl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// The sequencer holds one entry and walks through its bytes; it takes the
	// next entry in the same cycle that the last byte of the current one leaves.
	gtl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// A flush always leaves nothing held.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.flush) |=> fstat.pending_none)
		else $error("held letter survived a flush");

	// The queue can never be full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue status inconsistent");

	// An idle sequencer picks up a waiting entry in the next cycle.
	a_no_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(!qstat.empty && !out_ch.valid) |=> out_ch.valid)
		else $error("sequencer idle while the queue holds an entry");

endmodule

// ===== tb/greek_to_latin_transliterator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Greek to Latin transliterator: directed table, then random.
module greek_to_latin_transliterator_test;

	// The random part has about seventy-five input beats, so that with the
	// opening table the run sends about a hundred. The last stretch of it
	// runs with no gaps and no stalls so that the back-to-back path is covered.
	localparam int unsigned RANDOM_ITEMS = 75;
	localparam int unsigned QUIET_ITEMS  = 20;
	// Cycles with no beat on either channel are counted, and reaching this
	// limit is taken to mean a hang.
	localparam int unsigned STALL_LIMIT  = 1000;
	// This pause, after the last owed byte has gone out, lets any stray output
	// appear before the verdict.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned OPENING_ROWS = 25;

	// One output byte as the sink should see it.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} latin_beat_t;

	// One input beat. When typed is set, the expected output is one byte of value
	// c0 if n is nonzero and nothing if n is zero, instead of the predictor's.
	typedef struct packed {
		logic [7:0] b;
		logic       fl;
		logic       typed;
		logic [1:0] n;
		logic [7:0] c0;
	} stim_row_t;

	logic clk;
	logic arst_n;

	gtl_in_if  in_ch();
	gtl_out_if out_ch();

	greek_to_latin_transliterator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Our own copy of the letter the block holds back.
	gtl_pkg::pend_t held_letter;
	// Bytes that the current input beat should produce, first byte first.
	logic [7:0]  item_bytes[$];
	// Output bytes owed by the block, oldest first.
	latin_beat_t latin_due[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          gaps_on = 1'b1;
	int unsigned stall_left;

	// Directed opening. It starts with the extremes of the byte range and a
	// flush with nothing held, whose outputs are obvious. Then comes each
	// pairing rule: small nu plus tau, small mu plus pi, a held letter that
	// is released by another nu, capital pairs with capital followers, the
	// capital nu plus small tau case that owes a D and must not swallow the
	// next byte (here the longest glyph, giving four output bytes), the owed
	// B followed by a new held letter and a flush, and plain releases of
	// capital letters by an ordinary byte and by a flush.
	stim_row_t opening [OPENING_ROWS] = '{
		'{8'h00,            1'b0, 1'b1, 2'd1, 8'h00},
		'{8'hFF,            1'b0, 1'b1, 2'd1, 8'hFF},
		'{8'hA5,            1'b1, 1'b1, 2'd0, 8'h00},
		'{gtl_pkg::NU_SM,   1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::TAU_SM,  1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::MU_SM,   1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::PI_SM,   1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::NU_SM,   1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::NU_SM,   1'b0, 1'b0, 2'd0, 8'h00},
		'{8'd239,           1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::NU_CAP,  1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::TAU_CAP, 1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::MU_CAP,  1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::PI_CAP,  1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::NU_CAP,  1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::TAU_SM,  1'b0, 1'b0, 2'd0, 8'h00},
		'{8'd192,           1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::MU_CAP,  1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::PI_SM,   1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::NU_SM,   1'b0, 1'b0, 2'd0, 8'h00},
		'{8'h3C,            1'b1, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::NU_CAP,  1'b0, 1'b0, 2'd0, 8'h00},
		'{8'd193,           1'b0, 1'b0, 2'd0, 8'h00},
		'{gtl_pkg::MU_CAP,  1'b0, 1'b0, 2'd0, 8'h00},
		'{8'h00,            1'b1, 1'b0, 2'd0, 8'h00}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Latin spelling of one ISO-8859-7 byte. An empty string means the byte
	// has no entry and goes out as itself.
	function automatic string latin_spelling(input logic [7:0] b);
		case (b)
			8'd193: return "A";    8'd194: return "V";    8'd195: return "G";
			8'd196: return "D";    8'd197: return "E";    8'd198: return "Z";
			8'd199: return "H";    8'd200: return "8";    8'd201: return "I";
			8'd202: return "K";    8'd203: return "L";    8'd204: return "M";
			8'd205: return "N";    8'd206: return "KS";   8'd207: return "O";
			8'd208: return "P";    8'd209: return "R";    8'd210: return "S";
			8'd211: return "S";    8'd212: return "T";    8'd213: return "Y";
			8'd214: return "F";    8'd215: return "X";    8'd216: return "PS";
			8'd217: return "W";
			8'd225: return "a";    8'd226: return "v";    8'd227: return "g";
			8'd228: return "d";    8'd229: return "e";    8'd230: return "z";
			8'd231: return "h";    8'd232: return "8";    8'd233: return "i";
			8'd234: return "k";    8'd235: return "l";    8'd236: return "m";
			8'd237: return "n";    8'd238: return "ks";   8'd239: return "o";
			8'd240: return "p";    8'd241: return "r";    8'd242: return "s";
			8'd243: return "s";    8'd244: return "t";    8'd245: return "y";
			8'd246: return "f";    8'd247: return "x";    8'd248: return "ps";
			8'd249: return "w";
			8'd182: return "'A";   8'd184: return "'E";   8'd185: return "'H";
			8'd186: return "'I";   8'd188: return "'O";   8'd190: return "'Y";
			8'd191: return "'W";
			8'd220: return "a'";   8'd221: return "e'";   8'd222: return "h'";
			8'd223: return "i'";   8'd252: return "o'";   8'd253: return "y'";
			8'd254: return "w'";
			8'd192: return "i'\""; 8'd250: return "i\"";  8'd218: return "\"I";
			8'd224: return "y'\""; 8'd251: return "y\"";  8'd219: return "\"Y";
			default: return "";
		endcase
	endfunction

	function automatic void spell_into(input logic [7:0] b);
		string s;
		s = latin_spelling(b);
		if (s.len() == 0) begin
			item_bytes.push_back(b);
		end else begin
			for (int i = 0; i < s.len(); i++)
				item_bytes.push_back(s[i]);
		end
	endfunction

	// A byte seen with nothing held: nu and mu are held back silently, any
	// other byte goes out spelled.
	function automatic void take_fresh(input logic [7:0] b);
		case (b)
			gtl_pkg::NU_SM:  held_letter = gtl_pkg::P_SM_N;
			gtl_pkg::NU_CAP: held_letter = gtl_pkg::P_CAP_N;
			gtl_pkg::MU_SM:  held_letter = gtl_pkg::P_SM_M;
			gtl_pkg::MU_CAP: held_letter = gtl_pkg::P_CAP_M;
			default: begin
				held_letter = gtl_pkg::P_NONE;
				spell_into(b);
			end
		endcase
	endfunction

	// Works out the output bytes of one input beat and moves the held letter on.
	function automatic void transliterate(input logic [7:0] b, input logic fl);
		item_bytes.delete();
		if (fl) begin
			case (held_letter)
				gtl_pkg::P_SM_M:  item_bytes.push_back("m");
				gtl_pkg::P_SM_N:  item_bytes.push_back("n");
				gtl_pkg::P_CAP_N: item_bytes.push_back("N");
				gtl_pkg::P_CAP_M: item_bytes.push_back("M");
				gtl_pkg::P_OWE_D: item_bytes.push_back("D");
				gtl_pkg::P_OWE_B: item_bytes.push_back("B");
				default: ;
			endcase
			held_letter = gtl_pkg::P_NONE;
		end else begin
			case (held_letter)
				gtl_pkg::P_SM_N: begin
					held_letter = gtl_pkg::P_NONE;
					if (b == gtl_pkg::TAU_SM || b == gtl_pkg::TAU_CAP) begin
						item_bytes.push_back("d");
					end else begin
						item_bytes.push_back("n");
						spell_into(b);
					end
				end
				gtl_pkg::P_SM_M: begin
					held_letter = gtl_pkg::P_NONE;
					if (b == gtl_pkg::PI_SM || b == gtl_pkg::PI_CAP) begin
						item_bytes.push_back("b");
					end else begin
						item_bytes.push_back("m");
						spell_into(b);
					end
				end
				gtl_pkg::P_CAP_N: begin
					held_letter = gtl_pkg::P_NONE;
					if (b == gtl_pkg::TAU_SM) begin
						held_letter = gtl_pkg::P_OWE_D;
					end else if (b == gtl_pkg::TAU_CAP) begin
						item_bytes.push_back("D");
					end else begin
						item_bytes.push_back("N");
						spell_into(b);
					end
				end
				gtl_pkg::P_CAP_M: begin
					held_letter = gtl_pkg::P_NONE;
					if (b == gtl_pkg::PI_SM) begin
						held_letter = gtl_pkg::P_OWE_B;
					end else if (b == gtl_pkg::PI_CAP) begin
						item_bytes.push_back("B");
					end else begin
						item_bytes.push_back("M");
						spell_into(b);
					end
				end
				// The owed letter goes out first; the byte itself is then
				// treated as if nothing were held, so it may be held in turn.
				gtl_pkg::P_OWE_D: begin
					item_bytes.push_back("D");
					take_fresh(b);
				end
				gtl_pkg::P_OWE_B: begin
					item_bytes.push_back("B");
					take_fresh(b);
				end
				default: take_fresh(b);
			endcase
		end
	endfunction

	// Drives one input beat, starting and ending at a falling edge. At the
	// rising edge where the block takes the beat, its outputs are queued.
	task automatic send_beat(input stim_row_t r);
		latin_beat_t beat;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.byte_in <= r.b;
		in_ch.flush   <= r.fl;
		do @(posedge clk); while (!in_ch.ready);
		transliterate(r.b, r.fl);
		if (r.typed) begin
			item_bytes.delete();
			if (r.n != 0)
				item_bytes.push_back(r.c0);
		end
		foreach (item_bytes[i]) begin
			beat.ch   = item_bytes[i];
			beat.last = (i == item_bytes.size() - 1);
			latin_due.push_back(beat);
		end
		@(negedge clk);
	endtask

	task automatic send_random(input logic [7:0] b, input logic fl);
		stim_row_t r;
		r.b     = b;
		r.fl    = fl;
		r.typed = 1'b0;
		r.n     = 2'd0;
		r.c0    = 8'h00;
		send_beat(r);
	endtask

	// Output side: ready drops in bursts, each of a length drawn at random, while gaps are on.
	initial begin
		out_ch.ready = 1'b0;
		stall_left   = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left = stall_left - 1;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 14) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Checks each output beat against the oldest owed byte, and ends the run
	// if neither channel moves for too long.
	always @(posedge clk) begin
		latin_beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (latin_due.size() == 0) begin
				mismatches = mismatches + 1;
				$display("%0t: unexpected beat, char_out %h last %b", $time,
					out_ch.char_out, out_ch.last);
			end else begin
				want = latin_due.pop_front();
				if (out_ch.char_out !== want.ch) begin
					mismatches = mismatches + 1;
					$display("%0t: char_out expected %h got %h", $time,
						want.ch, out_ch.char_out);
				end
				if (out_ch.last !== want.last) begin
					mismatches = mismatches + 1;
					$display("%0t: last expected %b got %b (char_out %h)", $time,
						want.last, out_ch.last, out_ch.char_out);
				end
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat on either channel for %0d cycles", $time, quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		logic [7:0]  lead;
		logic [7:0]  follower;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.byte_in = 8'h00;
		in_ch.flush   = 1'b0;
		held_letter   = gtl_pkg::P_NONE;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (opening[i])
			send_beat(opening[i]);

		// Random part. Most beats are nu or mu followed by a tau or pi
		// (usually the partner that pairs with it) and then a letter or a
		// flush, so every held and owed state is reached with random content.
		// The rest is single Greek letters, any byte at all, and flushes.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = (sent < RANDOM_ITEMS - QUIET_ITEMS);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					case ($urandom_range(0, 3))
						0:       lead = gtl_pkg::NU_SM;
						1:       lead = gtl_pkg::NU_CAP;
						2:       lead = gtl_pkg::MU_SM;
						default: lead = gtl_pkg::MU_CAP;
					endcase
					if ($urandom_range(0, 3) != 0) begin
						if (lead == gtl_pkg::NU_SM || lead == gtl_pkg::NU_CAP)
							follower = $urandom_range(0, 1) ? gtl_pkg::TAU_SM
								: gtl_pkg::TAU_CAP;
						else
							follower = $urandom_range(0, 1) ? gtl_pkg::PI_SM
								: gtl_pkg::PI_CAP;
					end else begin
						case ($urandom_range(0, 3))
							0:       follower = gtl_pkg::TAU_SM;
							1:       follower = gtl_pkg::TAU_CAP;
							2:       follower = gtl_pkg::PI_SM;
							default: follower = gtl_pkg::PI_CAP;
						endcase
					end
					send_random(lead, 1'b0);
					send_random(follower, 1'b0);
					if ($urandom_range(0, 4) == 0)
						send_random(8'($urandom_range(0, 255)), 1'b1);
					else
						send_random(8'($urandom_range(182, 254)), 1'b0);
					sent = sent + 3;
				end
				4, 5, 6: begin
					send_random(8'($urandom_range(182, 254)), 1'b0);
					sent = sent + 1;
				end
				7, 8: begin
					send_random(8'($urandom_range(0, 255)), 1'b0);
					sent = sent + 1;
				end
				default: begin
					send_random(8'($urandom_range(0, 255)), 1'b1);
					sent = sent + 1;
				end
			endcase
		end
		// Release whatever letter is still held.
		send_random(8'($urandom_range(0, 255)), 1'b1);
		in_ch.valid <= 1'b0;

		while (latin_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gtl_pkg.sv
rtl/gtl_channels.sv
rtl/gtl_front.sv
rtl/gtl_queue.sv
rtl/gtl_back.sv
rtl/greek_to_latin_transliterator.sv
tb/greek_to_latin_transliterator_test.sv
